@@ sv/ssp_pkg.sv @@
// Shared types and constants for the signature subpacket parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int unsigned TypeW  = 7;
    localparam int unsigned KindW  = 5;
    localparam int unsigned ValueW = 64;
    localparam int unsigned ErrW   = 2;
    localparam int unsigned PosW   = 5;
    localparam int unsigned LenW   = 16;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [KindW-1:0]  token_kind;
        logic [ValueW-1:0] token_value;
        logic [ErrW-1:0]   error_code;
    } t_out_item;

    typedef enum logic [5:0] {
        PH_INIT   = 6'b000001,
        PH_NAME   = 6'b000010,
        PH_VALUE  = 6'b000100,
        PH_REASON = 6'b001000,
        PH_THASH  = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [ErrW-1:0] ERR_NONE  = 2'd0;
    localparam logic [ErrW-1:0] ERR_DONE  = 2'd1;
    localparam logic [ErrW-1:0] ERR_STATE = 2'd2;

    localparam logic [PosW-1:0] REVKEY_LEN = 5'd22;
    localparam logic [PosW-1:0] ISSUER_LEN = 5'd8;
    localparam logic [PosW-1:0] TIME_LEN   = 5'd4;
    localparam logic [PosW-1:0] PAIR_LEN   = 5'd2;

    // subpacket type numbers
    localparam logic [TypeW-1:0] SP_CREATION   = 7'd2;
    localparam logic [TypeW-1:0] SP_SIG_EXP    = 7'd3;
    localparam logic [TypeW-1:0] SP_EXPORTABLE = 7'd4;
    localparam logic [TypeW-1:0] SP_TRUST      = 7'd5;
    localparam logic [TypeW-1:0] SP_REGEX      = 7'd6;
    localparam logic [TypeW-1:0] SP_REVOCABLE  = 7'd7;
    localparam logic [TypeW-1:0] SP_KEY_EXP    = 7'd9;
    localparam logic [TypeW-1:0] SP_PREF_SYM   = 7'd11;
    localparam logic [TypeW-1:0] SP_REVKEY     = 7'd12;
    localparam logic [TypeW-1:0] SP_ISSUER     = 7'd16;
    localparam logic [TypeW-1:0] SP_NOTATION   = 7'd20;
    localparam logic [TypeW-1:0] SP_PREF_HASH  = 7'd21;
    localparam logic [TypeW-1:0] SP_PREF_COMP  = 7'd22;
    localparam logic [TypeW-1:0] SP_KS_PREFS   = 7'd23;
    localparam logic [TypeW-1:0] SP_PREF_KS    = 7'd24;
    localparam logic [TypeW-1:0] SP_PRIMARY    = 7'd25;
    localparam logic [TypeW-1:0] SP_POLICY     = 7'd26;
    localparam logic [TypeW-1:0] SP_KEY_FLAGS  = 7'd27;
    localparam logic [TypeW-1:0] SP_SIGNER_UID = 7'd28;
    localparam logic [TypeW-1:0] SP_REV_REASON = 7'd29;
    localparam logic [TypeW-1:0] SP_FEATURES   = 7'd30;
    localparam logic [TypeW-1:0] SP_TARGET     = 7'd31;
    localparam logic [TypeW-1:0] SP_EMBEDDED   = 7'd32;

    // token kinds
    localparam logic [KindW-1:0] TK_CREATION    = 5'd0;
    localparam logic [KindW-1:0] TK_ISSUER      = 5'd1;
    localparam logic [KindW-1:0] TK_KEY_EXP     = 5'd2;
    localparam logic [KindW-1:0] TK_PREF_SYM    = 5'd3;
    localparam logic [KindW-1:0] TK_PREF_HASH   = 5'd4;
    localparam logic [KindW-1:0] TK_PREF_COMP   = 5'd5;
    localparam logic [KindW-1:0] TK_SIG_EXP     = 5'd6;
    localparam logic [KindW-1:0] TK_EXPORTABLE  = 5'd7;
    localparam logic [KindW-1:0] TK_REVOCABLE   = 5'd8;
    localparam logic [KindW-1:0] TK_TRUST_LVL   = 5'd9;
    localparam logic [KindW-1:0] TK_TRUST_AMT   = 5'd10;
    localparam logic [KindW-1:0] TK_REGEX       = 5'd11;
    localparam logic [KindW-1:0] TK_RK_CLASS    = 5'd12;
    localparam logic [KindW-1:0] TK_RK_ALG      = 5'd13;
    localparam logic [KindW-1:0] TK_RK_FPR      = 5'd14;
    localparam logic [KindW-1:0] TK_NOT_FLAGS   = 5'd15;
    localparam logic [KindW-1:0] TK_NOT_NAME    = 5'd16;
    localparam logic [KindW-1:0] TK_NOT_VALUE   = 5'd17;
    localparam logic [KindW-1:0] TK_KS_PREFS    = 5'd18;
    localparam logic [KindW-1:0] TK_PREF_KS     = 5'd19;
    localparam logic [KindW-1:0] TK_PRIMARY     = 5'd20;
    localparam logic [KindW-1:0] TK_POLICY      = 5'd21;
    localparam logic [KindW-1:0] TK_KEY_FLAG    = 5'd22;
    localparam logic [KindW-1:0] TK_SIGNER_UID  = 5'd23;
    localparam logic [KindW-1:0] TK_REV_CODE    = 5'd24;
    localparam logic [KindW-1:0] TK_REV_REASON  = 5'd25;
    localparam logic [KindW-1:0] TK_FEATURE     = 5'd26;
    localparam logic [KindW-1:0] TK_TGT_PK_ALG  = 5'd27;
    localparam logic [KindW-1:0] TK_TGT_HASH_ALG = 5'd28;
    localparam logic [KindW-1:0] TK_TGT_HASH    = 5'd29;
    localparam logic [KindW-1:0] TK_EMBEDDED    = 5'd30;

endpackage

@@ sv/ssp_in_stage.sv @@
// Input register stage of the subpacket parser.
// Depends on ssp_pkg for the input item type.
`timescale 1ns / 1ps

module ssp_in_stage import ssp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     w_load;

    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ sv/ssp_parser.sv @@
// Parser state and per-byte next-state / token logic.
// Depends on ssp_pkg for item types, phases, token kinds and type codes.
`timescale 1ns / 1ps

module ssp_parser import ssp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TypeW-1:0] i_cfg_data,
    input  logic             i_fire,
    input  t_in_item         i_item,
    output logic             o_res_valid,
    output t_out_item        o_res
);

    logic [TypeW-1:0]  r_type;
    t_phase            r_phase, n_phase;
    logic [ValueW-1:0] r_coll, n_coll;
    logic [PosW-1:0]   r_pos, n_pos;
    logic [LenW-1:0]   r_nbl, n_nbl;
    logic [LenW-1:0]   r_vbl, n_vbl;
    logic [ErrW-1:0]   r_err, n_err;

    t_phase            w_ph;
    logic [ValueW-1:0] w_shift;
    logic [PosW-1:0]   w_pos1;
    logic [7:0]        w_b;
    logic [LenW-1:0]   w_dec;

    always_comb begin
        n_phase     = r_phase;
        n_coll      = r_coll;
        n_pos       = r_pos;
        n_nbl       = r_nbl;
        n_vbl       = r_vbl;
        n_err       = r_err;
        w_ph        = r_phase;
        w_b         = i_item.data_byte;
        w_shift     = {r_coll[ValueW-9:0], w_b};
        w_pos1      = r_pos + 5'd1;
        w_dec       = '0;
        o_res_valid = 1'b0;
        o_res.token_kind  = TK_CREATION;
        o_res.token_value = {{(ValueW-8){1'b0}}, w_b};
        o_res.error_code  = ERR_NONE;

        if (r_err != ERR_NONE) begin
            o_res_valid       = 1'b1;
            o_res.token_value = '0;
            o_res.error_code  = r_err;
        end else if (i_item.operation == OP_FINISH) begin
            if (r_phase == PH_DONE) begin
                n_err             = ERR_DONE;
                o_res_valid       = 1'b1;
                o_res.token_value = '0;
                o_res.error_code  = ERR_DONE;
            end else begin
                n_phase = PH_DONE;
            end
        end else begin
            if (w_ph == PH_NAME) begin
                if (r_nbl != '0) begin
                    w_dec = r_nbl - 16'd1;
                    n_nbl = w_dec;
                    if (w_dec == '0) begin
                        n_phase = (r_vbl != '0) ? PH_VALUE : PH_INIT;
                    end
                    o_res_valid      = 1'b1;
                    o_res.token_kind = TK_NOT_NAME;
                end else begin
                    w_ph    = PH_VALUE;
                    n_phase = PH_VALUE;
                end
            end
            if (!o_res_valid && w_ph == PH_VALUE) begin
                if (r_vbl != '0) begin
                    w_dec = r_vbl - 16'd1;
                    n_vbl = w_dec;
                    if (w_dec == '0) begin
                        n_phase = PH_INIT;
                    end
                    o_res_valid      = 1'b1;
                    o_res.token_kind = TK_NOT_VALUE;
                end else begin
                    w_ph    = PH_INIT;
                    n_phase = PH_INIT;
                end
            end
            if (!o_res_valid) begin
                unique case (w_ph)
                    PH_INIT: begin
                        unique case (r_type)
                            SP_CREATION, SP_KEY_EXP, SP_SIG_EXP, SP_ISSUER: begin
                                n_coll = w_shift;
                                n_pos  = w_pos1;
                                if (w_pos1 >= ((r_type == SP_ISSUER) ? ISSUER_LEN : TIME_LEN))
                                begin
                                    n_pos       = '0;
                                    n_coll      = '0;
                                    o_res_valid = 1'b1;
                                    if (r_type == SP_ISSUER) begin
                                        o_res.token_kind  = TK_ISSUER;
                                        o_res.token_value = w_shift;
                                    end else begin
                                        o_res.token_kind  = (r_type == SP_CREATION)
                                            ? TK_CREATION
                                            : ((r_type == SP_KEY_EXP) ? TK_KEY_EXP
                                                                      : TK_SIG_EXP);
                                        o_res.token_value = {32'd0, w_shift[31:0]};
                                    end
                                end
                            end
                            SP_PREF_SYM: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_PREF_SYM;
                            end
                            SP_PREF_HASH: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_PREF_HASH;
                            end
                            SP_PREF_COMP: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_PREF_COMP;
                            end
                            SP_EXPORTABLE: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_EXPORTABLE;
                            end
                            SP_REVOCABLE: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_REVOCABLE;
                            end
                            SP_TRUST: begin
                                o_res_valid = 1'b1;
                                if (r_pos == '0) begin
                                    n_pos            = PAIR_LEN - 5'd1;
                                    o_res.token_kind = TK_TRUST_LVL;
                                end else begin
                                    n_pos            = '0;
                                    o_res.token_kind = TK_TRUST_AMT;
                                end
                            end
                            SP_REGEX: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_REGEX;
                            end
                            SP_REVKEY: begin
                                o_res_valid = 1'b1;
                                n_pos = (r_pos >= REVKEY_LEN - 5'd1) ? '0 : w_pos1;
                                if (r_pos == 5'd0) begin
                                    o_res.token_kind = TK_RK_CLASS;
                                end else if (r_pos == 5'd1) begin
                                    o_res.token_kind = TK_RK_ALG;
                                end else begin
                                    o_res.token_kind = TK_RK_FPR;
                                end
                            end
                            SP_NOTATION: begin
                                n_coll = w_shift;
                                n_pos  = w_pos1;
                                if (r_pos >= ISSUER_LEN - 5'd1) begin
                                    n_nbl  = w_shift[31:16];
                                    n_vbl  = w_shift[15:0];
                                    n_pos  = '0;
                                    n_coll = '0;
                                    if (w_shift[31:16] != '0) begin
                                        n_phase = PH_NAME;
                                    end else if (w_shift[15:0] != '0) begin
                                        n_phase = PH_VALUE;
                                    end else begin
                                        n_phase = PH_INIT;
                                    end
                                end else if (r_pos == TIME_LEN - 5'd1) begin
                                    o_res_valid       = 1'b1;
                                    o_res.token_kind  = TK_NOT_FLAGS;
                                    o_res.token_value = {32'd0, w_shift[31:0]};
                                end
                            end
                            SP_KS_PREFS: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_KS_PREFS;
                            end
                            SP_PREF_KS: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_PREF_KS;
                            end
                            SP_PRIMARY: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_PRIMARY;
                            end
                            SP_POLICY: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_POLICY;
                            end
                            SP_KEY_FLAGS: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_KEY_FLAG;
                            end
                            SP_SIGNER_UID: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_SIGNER_UID;
                            end
                            SP_REV_REASON: begin
                                o_res_valid      = 1'b1;
                                o_res.token_kind = TK_REV_CODE;
                                n_phase          = PH_REASON;
                            end
                            SP_FEATURES: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_FEATURE;
                            end
                            SP_TARGET: begin
                                o_res_valid = 1'b1;
                                if (r_pos == '0) begin
                                    n_pos            = PAIR_LEN - 5'd1;
                                    o_res.token_kind = TK_TGT_PK_ALG;
                                end else begin
                                    n_pos            = '0;
                                    n_phase          = PH_THASH;
                                    o_res.token_kind = TK_TGT_HASH_ALG;
                                end
                            end
                            SP_EMBEDDED: begin
                                o_res_valid = 1'b1; o_res.token_kind = TK_EMBEDDED;
                            end
                            default: begin
                            end
                        endcase
                    end
                    PH_REASON: begin
                        o_res_valid      = 1'b1;
                        o_res.token_kind = TK_REV_REASON;
                    end
                    PH_THASH: begin
                        o_res_valid      = 1'b1;
                        o_res.token_kind = TK_TGT_HASH;
                    end
                    default: begin
                        n_err             = ERR_STATE;
                        o_res_valid       = 1'b1;
                        o_res.token_value = '0;
                        o_res.error_code  = ERR_STATE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= '0;
            r_phase <= PH_INIT;
            r_coll  <= '0;
            r_pos   <= '0;
            r_nbl   <= '0;
            r_vbl   <= '0;
            r_err   <= ERR_NONE;
        end else begin
            if (i_cfg_we) begin
                r_type <= i_cfg_data;
            end
            if (i_fire) begin
                r_phase <= n_phase;
                r_coll  <= n_coll;
                r_pos   <= n_pos;
                r_nbl   <= n_nbl;
                r_vbl   <= n_vbl;
                r_err   <= n_err;
            end
        end
    end

endmodule

@@ sv/ssp_out_stage.sv @@
// Result register stage of the subpacket parser.
// Depends on ssp_pkg for the result item type.
`timescale 1ns / 1ps

module ssp_out_stage import ssp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_res,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    logic      r_valid;
    t_out_item r_data;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_data <= i_res;
        end
    end

endmodule

@@ sv/signature_subpacket_parser_core.sv @@
// Signature subpacket body parser: one body byte or finish per transaction.
// A result passes through the input register, then the result register, once its
// input transaction is accepted; transactions with no token show nothing.
// Throughput: one transaction per cycle; a stalled result holds the input stage.
// Reset (synchronous, active low) clears both stage valids, parser state and
// the subpacket type register. Uses ssp_pkg, ssp_in_stage, ssp_parser, ssp_out_stage.
`timescale 1ns / 1ps

module signature_subpacket_parser_core import ssp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_in_item         i_data,
    output logic             o_stall,
    output logic             o_valid,
    output t_out_item        o_data,
    input  logic             i_stall,
    input  logic             i_cfg_valid,
    input  logic [TypeW-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    logic      w_out_ready;
    logic      w_item_valid;
    t_in_item  w_item;
    logic      w_fire;
    logic      w_res_valid;
    t_out_item w_res;

    assign o_cfg_ready = 1'b1;
    assign w_fire      = w_item_valid && w_out_ready;

    ssp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_item    (i_data),
        .o_stall   (o_stall),
        .i_advance (w_out_ready),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    ssp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ssp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fire && w_res_valid),
        .i_res   (w_res),
        .o_ready (w_out_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

@@ sv/ssp_checker.sv @@
// Port-level assertions for the subpacket parser, bound to the top level.
// Depends on ssp_pkg for error codes and token kinds.
`timescale 1ns / 1ps

module ssp_checker import ssp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_stall,
    input logic      o_valid,
    input t_out_item o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error_code != ERR_NONE |->
            o_data.token_kind == TK_CREATION && o_data.token_value == '0)
        else $error("error transaction with nonzero payload");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.error_code == ERR_NONE || o_data.error_code == ERR_DONE ||
                    o_data.error_code == ERR_STATE)
        else $error("bad error code");

    a_byte_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.error_code == ERR_NONE && o_data.token_kind != TK_ISSUER |->
            o_data.token_value[63:32] == '0)
        else $error("narrow token with upper bits set");

endmodule

bind signature_subpacket_parser_core ssp_checker u_ssp_checker (.*);

@@ tb/signature_subpacket_parser_core_test.sv @@
// Self-checking testbench for signature_subpacket_parser_core: bursty byte/finish stream in,
// randomly stalled token stream out, every token checked against an in-bench parser model.
// Depends on ssp_pkg and the signature_subpacket_parser_core RTL only.
`timescale 1ns / 1ps

module signature_subpacket_parser_core_test;

    import ssp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1500;

    typedef struct packed {
        t_phase            ph;
        logic [ValueW-1:0] acc;
        logic [PosW-1:0]   pos;
        logic [LenW-1:0]   name_left;
        logic [LenW-1:0]   value_left;
        logic [ErrW-1:0]   err;
        logic [TypeW-1:0]  sp_type;
    } t_parse_state;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    t_in_item         i_data = '0;
    logic             o_stall;
    logic             o_valid;
    t_out_item        o_data;
    logic             i_stall = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [TypeW-1:0] i_cfg_data = '0;
    logic             o_cfg_ready;

    t_in_item         pending[$];
    t_out_item        expected_tokens[$];
    t_parse_state     model;
    t_parse_state     shadow;
    logic [TypeW-1:0] safe_types[$];

    logic in_taken = 1'b0;
    logic cfg_taken = 1'b0;
    int   queued_count = 0;
    int   in_count = 0;
    int   out_count = 0;
    int   cfg_count = 0;
    int   random_items = 0;
    int   fail_count = 0;
    int   idle_cycles = 0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   stall_run = 0;
    int   stall_mode = 0;
    int   stall_tick = 0;

    signature_subpacket_parser_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_out_item make_token(input logic [KindW-1:0] kind,
                                             input logic [ValueW-1:0] value,
                                             input logic [ErrW-1:0] err);
        t_out_item tok;
        tok.token_kind  = kind;
        tok.token_value = value;
        tok.error_code  = err;
        return tok;
    endfunction

    function automatic bit is_known(input logic [TypeW-1:0] t);
        case (t)
            SP_CREATION, SP_SIG_EXP, SP_EXPORTABLE, SP_TRUST, SP_REGEX, SP_REVOCABLE,
            SP_KEY_EXP, SP_PREF_SYM, SP_REVKEY, SP_ISSUER, SP_NOTATION, SP_PREF_HASH,
            SP_PREF_COMP, SP_KS_PREFS, SP_PREF_KS, SP_PRIMARY, SP_POLICY, SP_KEY_FLAGS,
            SP_SIGNER_UID, SP_REV_REASON, SP_FEATURES, SP_TARGET, SP_EMBEDDED: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // big-endian fixed field; emits once len bytes (or more, after a type switch) are in
    function automatic bit collect_fixed(inout t_parse_state s, input logic [7:0] b,
                                         input logic [PosW-1:0] len,
                                         input logic [KindW-1:0] kind, input bit wide,
                                         output t_out_item tok);
        s.acc = {s.acc[ValueW-9:0], b};
        s.pos = s.pos + 5'd1;
        if (s.pos < len) return 1'b0;
        tok = make_token(kind, wide ? s.acc : {32'd0, s.acc[31:0]}, ERR_NONE);
        s.pos = '0;
        s.acc = '0;
        return 1'b1;
    endfunction

    function automatic bit parse_body_item(inout t_parse_state s, input t_in_item it,
                                           output t_out_item tok);
        logic [7:0]       b;
        logic [PosW-1:0]  p;
        logic [KindW-1:0] kind;
        b = it.data_byte;
        if (s.err != ERR_NONE) begin
            tok = make_token('0, '0, s.err);
            return 1'b1;
        end
        if (it.operation == OP_FINISH) begin
            if (s.ph == PH_DONE) begin
                s.err = ERR_DONE;
                tok = make_token('0, '0, ERR_DONE);
                return 1'b1;
            end
            s.ph = PH_DONE;
            return 1'b0;
        end
        if (s.ph == PH_NAME) begin
            if (s.name_left != 0) begin
                s.name_left = s.name_left - 16'd1;
                if (s.name_left == 0) s.ph = (s.value_left != 0) ? PH_VALUE : PH_INIT;
                tok = make_token(TK_NOT_NAME, {56'd0, b}, ERR_NONE);
                return 1'b1;
            end
            s.ph = PH_VALUE;
        end
        if (s.ph == PH_VALUE) begin
            if (s.value_left != 0) begin
                s.value_left = s.value_left - 16'd1;
                if (s.value_left == 0) s.ph = PH_INIT;
                tok = make_token(TK_NOT_VALUE, {56'd0, b}, ERR_NONE);
                return 1'b1;
            end
            s.ph = PH_INIT;
        end
        if (s.ph == PH_REASON) begin
            tok = make_token(TK_REV_REASON, {56'd0, b}, ERR_NONE);
            return 1'b1;
        end
        if (s.ph == PH_THASH) begin
            tok = make_token(TK_TGT_HASH, {56'd0, b}, ERR_NONE);
            return 1'b1;
        end
        if (s.ph != PH_INIT) begin
            s.err = ERR_STATE;
            tok = make_token('0, '0, ERR_STATE);
            return 1'b1;
        end
        p = s.pos;
        case (s.sp_type)
            SP_CREATION:   return collect_fixed(s, b, TIME_LEN, TK_CREATION, 1'b0, tok);
            SP_ISSUER:     return collect_fixed(s, b, ISSUER_LEN, TK_ISSUER, 1'b1, tok);
            SP_KEY_EXP:    return collect_fixed(s, b, TIME_LEN, TK_KEY_EXP, 1'b0, tok);
            SP_SIG_EXP:    return collect_fixed(s, b, TIME_LEN, TK_SIG_EXP, 1'b0, tok);
            SP_PREF_SYM:   kind = TK_PREF_SYM;
            SP_PREF_HASH:  kind = TK_PREF_HASH;
            SP_PREF_COMP:  kind = TK_PREF_COMP;
            SP_EXPORTABLE: kind = TK_EXPORTABLE;
            SP_REVOCABLE:  kind = TK_REVOCABLE;
            SP_REGEX:      kind = TK_REGEX;
            SP_KS_PREFS:   kind = TK_KS_PREFS;
            SP_PREF_KS:    kind = TK_PREF_KS;
            SP_PRIMARY:    kind = TK_PRIMARY;
            SP_POLICY:     kind = TK_POLICY;
            SP_KEY_FLAGS:  kind = TK_KEY_FLAG;
            SP_SIGNER_UID: kind = TK_SIGNER_UID;
            SP_FEATURES:   kind = TK_FEATURE;
            SP_EMBEDDED:   kind = TK_EMBEDDED;
            SP_TRUST: begin
                s.pos = (p == 5'd0) ? 5'd1 : 5'd0;
                kind = (p == 5'd0) ? TK_TRUST_LVL : TK_TRUST_AMT;
            end
            SP_REVKEY: begin
                s.pos = (p >= REVKEY_LEN - 5'd1) ? 5'd0 : p + 5'd1;
                kind = (p == 5'd0) ? TK_RK_CLASS : (p == 5'd1) ? TK_RK_ALG : TK_RK_FPR;
            end
            SP_REV_REASON: begin
                s.ph = PH_REASON;
                kind = TK_REV_CODE;
            end
            SP_TARGET: begin
                if (p == 5'd0) begin
                    s.pos = 5'd1;
                    kind = TK_TGT_PK_ALG;
                end else begin
                    s.pos = 5'd0;
                    s.ph = PH_THASH;
                    kind = TK_TGT_HASH_ALG;
                end
            end
            SP_NOTATION: begin
                s.acc = {s.acc[ValueW-9:0], b};
                s.pos = p + 5'd1;
                if (p >= ISSUER_LEN - 5'd1) begin
                    s.name_left  = s.acc[31:16];
                    s.value_left = s.acc[15:0];
                    s.pos = '0;
                    s.acc = '0;
                    if (s.name_left != 0)       s.ph = PH_NAME;
                    else if (s.value_left != 0) s.ph = PH_VALUE;
                    else                        s.ph = PH_INIT;
                    return 1'b0;
                end
                if (p != TIME_LEN - 5'd1) return 1'b0;
                tok = make_token(TK_NOT_FLAGS, {32'd0, s.acc[31:0]}, ERR_NONE);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
        tok = make_token(kind, {56'd0, b}, ERR_NONE);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [ValueW-1:0] got,
                                   input logic [ValueW-1:0] want);
        $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic queue_item(input logic op, input logic [7:0] b);
        t_in_item  it;
        t_out_item scratch;
        it.operation = op;
        it.data_byte = b;
        pending.push_back(it);
        queued_count++;
        if (is_known(shadow.sp_type)) random_items++;
        void'(parse_body_item(shadow, it, scratch));
    endtask

    task automatic wait_drained();
        while (in_count != queued_count || expected_tokens.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_type(input logic [TypeW-1:0] t);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= t;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
        shadow.sp_type = t;
    endtask

    // sender: bursts of random length separated by random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (gap_left != 0 || pending.size() == 0) begin
                if (gap_left != 0) gap_left--;
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_data  <= pending.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: stall pattern switches between none, random and periodic
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_run = $urandom_range(16, 96);
        end else begin
            stall_run--;
        end
        stall_tick++;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 2) == 0);
            default: i_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin : monitor
        t_out_item tok;
        t_out_item want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end else begin
            in_taken  <= i_valid && !o_stall;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                model.sp_type = i_cfg_data;
                cfg_count++;
            end
            if (i_valid && !o_stall) begin
                in_count++;
                if (parse_body_item(model, i_data, tok)) expected_tokens.push_back(tok);
            end
            if (o_valid && !i_stall) begin
                out_count++;
                if (expected_tokens.size() == 0) begin
                    report_mismatch("result with nothing expected, kind",
                                    64'(o_data.token_kind), '0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (o_data.token_kind !== want.token_kind)
                        report_mismatch("token_kind", 64'(o_data.token_kind),
                                        64'(want.token_kind));
                    if (o_data.token_value !== want.token_value)
                        report_mismatch("token_value", o_data.token_value, want.token_value);
                    if (o_data.error_code !== want.error_code)
                        report_mismatch("error_code", 64'(o_data.error_code),
                                        64'(want.error_code));
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("signature_subpacket_parser_core verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [TypeW-1:0] t;
        logic [7:0]       seq[$];
        logic [15:0]      nlen;
        logic [15:0]      vlen;
        int               nseq;
        int               len;
        int               keep;
        bit               reason_end;
        bit               double_finish;
        model = '0;
        model.ph = PH_INIT;
        shadow = model;
        safe_types = '{SP_CREATION, SP_SIG_EXP, SP_EXPORTABLE, SP_TRUST, SP_REGEX,
                       SP_REVOCABLE, SP_KEY_EXP, SP_PREF_SYM, SP_REVKEY, SP_ISSUER,
                       SP_NOTATION, SP_PREF_HASH, SP_PREF_COMP, SP_KS_PREFS, SP_PREF_KS,
                       SP_PRIMARY, SP_POLICY, SP_KEY_FLAGS, SP_SIGNER_UID, SP_FEATURES,
                       SP_EMBEDDED};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: unknown type at both register extremes, a time, an empty notation and one with a one-byte value
        write_type(7'd0);
        queue_item(OP_BYTE, 8'h00);
        queue_item(OP_BYTE, 8'hFF);
        write_type(SP_CREATION);
        queue_item(OP_BYTE, 8'h00);
        queue_item(OP_BYTE, 8'hFF);
        queue_item(OP_BYTE, 8'h80);
        queue_item(OP_BYTE, 8'h01);
        write_type(SP_NOTATION);
        repeat (4) queue_item(OP_BYTE, 8'hFF);
        repeat (4) queue_item(OP_BYTE, 8'h00);
        queue_item(OP_BYTE, 8'h80);
        repeat (6) queue_item(OP_BYTE, 8'h00);
        queue_item(OP_BYTE, 8'h01);
        queue_item(OP_BYTE, 8'hAB);
        write_type(7'd127);
        queue_item(OP_BYTE, 8'h5A);

        // random: one subpacket type per round, mostly well-formed fields
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 12) begin
                do t = 7'($urandom_range(0, 127)); while (is_known(t));
            end else begin
                t = safe_types[$urandom_range(0, safe_types.size() - 1)];
            end
            // a notation header must start on a clean boundary or lengths run wild
            if (t == SP_NOTATION && (shadow.ph != PH_INIT || shadow.pos != 0)) t = SP_ISSUER;
            write_type(t);
            nseq = $urandom_range(1, 6);
            for (int i = 0; i < nseq; i++) begin
                seq.delete();
                case (t)
                    SP_CREATION, SP_SIG_EXP, SP_KEY_EXP: len = 4;
                    SP_ISSUER:   len = 8;
                    SP_TRUST:    len = 2;
                    SP_REVKEY:   len = 22;
                    SP_NOTATION: len = 0;
                    default:     len = is_known(t) ? $urandom_range(1, 8) : $urandom_range(1, 4);
                endcase
                if (t == SP_NOTATION) begin
                    nlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
                    vlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
                    repeat (4) seq.push_back(8'($urandom));
                    seq.push_back(nlen[15:8]);
                    seq.push_back(nlen[7:0]);
                    seq.push_back(vlen[15:8]);
                    seq.push_back(vlen[7:0]);
                    repeat (int'(nlen) + int'(vlen)) seq.push_back(8'($urandom));
                end else begin
                    repeat (len) seq.push_back(8'($urandom));
                end
                keep = seq.size();
                // broken field, only as the last one of the round
                if (i == nseq - 1 && keep > 1 && $urandom_range(0, 2) == 0)
                    keep = $urandom_range(1, keep - 1);
                for (int k = 0; k < keep; k++) queue_item(OP_BYTE, seq[k]);
            end
        end

        // tail: realign, enter a terminal phase, then finish and the sticky errors
        reason_end = $urandom_range(0, 1);
        double_finish = $urandom_range(0, 1);
        write_type(SP_CREATION);
        while (shadow.ph != PH_INIT || shadow.pos != 0) queue_item(OP_BYTE, 8'($urandom));
        if (reason_end) begin
            write_type(SP_REV_REASON);
            repeat (4) queue_item(OP_BYTE, 8'($urandom));
        end else begin
            write_type(SP_TARGET);
            repeat (5) queue_item(OP_BYTE, 8'($urandom));
        end
        queue_item(OP_FINISH, 8'($urandom));
        if (double_finish) queue_item(OP_FINISH, 8'($urandom));
        else               queue_item(OP_BYTE, 8'($urandom));
        repeat (3) queue_item(1'($urandom), 8'($urandom));
        wait_drained();

        $display("summary: %0d transactions in, %0d results checked, %0d type writes",
                 in_count, out_count, cfg_count);
        $display("summary: body ended in %s, closed by %s",
                 reason_end ? "revocation reason" : "signature target hash",
                 double_finish ? "a repeated finish" : "data after finish");
        if (fail_count == 0) begin
            $display("signature_subpacket_parser_core verification clean");
        end else begin
            $display("signature_subpacket_parser_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ssp_pkg.sv
sv/ssp_in_stage.sv
sv/ssp_parser.sv
sv/ssp_out_stage.sv
sv/signature_subpacket_parser_core.sv
sv/ssp_checker.sv
tb/signature_subpacket_parser_core_test.sv
